[hw/rtl/dbsd_pkg.sv]
// ----------------------------------------------------------------------------
// dbsd_pkg
// Shared widths, codes and register indexes of the dual byte sequence detector.
// ----------------------------------------------------------------------------
package dbsd_pkg;

    localparam int KIND_W    = 2;
    localparam int BYTE_W    = 8;
    localparam int VERDICT_W = 2;
    localparam int PAT_W     = 64;
    localparam int LEN_W     = 4;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    typedef logic [KIND_W-1:0]    wait_kind_t;
    typedef logic [BYTE_W-1:0]    rx_byte_t;
    typedef logic [VERDICT_W-1:0] verdict_t;
    typedef logic [PAT_W-1:0]     pattern_t;
    typedef logic [LEN_W-1:0]     length_t;
    typedef logic [CFG_IDX_W-1:0] cfg_index_t;

    // Wait kinds
    localparam wait_kind_t WAIT_GUARD = 2'd0;
    localparam wait_kind_t WAIT_ENTRY = 2'd1;

    // Verdict codes
    localparam verdict_t VERDICT_NONE   = 2'd0;
    localparam verdict_t VERDICT_FIRST  = 2'd1;
    localparam verdict_t VERDICT_SECOND = 2'd2;

    // Register indexes
    localparam cfg_index_t REG_MATCHING_ENABLED     = 3'd0;
    localparam cfg_index_t REG_GUARD_PATTERN        = 3'd1;
    localparam cfg_index_t REG_GUARD_LENGTH         = 3'd2;
    localparam cfg_index_t REG_ENTRY_PATTERN_FIRST  = 3'd3;
    localparam cfg_index_t REG_ENTRY_FIRST_LENGTH   = 3'd4;
    localparam cfg_index_t REG_ENTRY_PATTERN_SECOND = 3'd5;
    localparam cfg_index_t REG_ENTRY_SECOND_LENGTH  = 3'd6;

    localparam rx_byte_t WILDCARD_BYTE = 8'h01;

endpackage

[hw/rtl/dbsd_if.sv]
// ----------------------------------------------------------------------------
// dbsd_in_if / dbsd_out_if
// Valid/ready channels carrying received bytes in and verdicts out.
// ----------------------------------------------------------------------------
interface dbsd_in_if import dbsd_pkg::*; ();
    logic       valid;
    logic       ready;
    wait_kind_t wait_kind;
    rx_byte_t   rx_byte;

    modport source (output valid, output wait_kind, output rx_byte, input ready);
    modport sink   (input valid, input wait_kind, input rx_byte, output ready);
endinterface

interface dbsd_out_if import dbsd_pkg::*; ();
    logic     valid;
    logic     ready;
    verdict_t verdict;

    modport source (output valid, output verdict, input ready);
    modport sink   (input valid, input verdict, output ready);
endinterface

[hw/rtl/dual_byte_sequence_detector_core.sv]
// ----------------------------------------------------------------------------
// dual_byte_sequence_detector_core
// Matches a received byte stream against a guard pattern or a pair of entry
// patterns, with 0x01 as a wildcard pattern byte.
// ----------------------------------------------------------------------------
// The verdict is registered and valid in the cycle after its item is accepted.
// Throughput: one item per cycle; the index update of each pattern is a
// single compare and increment done in the accept cycle.
// The output register decouples the sides: a new item is taken while a
// verdict waits, unless that verdict is stalled by the sink.
// Reset clears the detector to idle and the registers to their defaults.
module dual_byte_sequence_detector_core
    import dbsd_pkg::*;
#(
    parameter int MAX_PATTERN_BYTES = 8
)
(
    input  logic              clk,
    input  logic              rst_n,
    dbsd_in_if.sink           in_ch,
    dbsd_out_if.source        out_ch,
    input  logic              cfg_we,
    input  cfg_index_t        cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int IDX_W = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;
    localparam length_t MAX_LEN = LEN_W'(MAX_PATTERN_BYTES);

    typedef logic [IDX_W-1:0] idx_t;

    // Configuration registers
    logic     matching_enabled_reg;
    pattern_t guard_pattern_reg;
    length_t  guard_length_reg;
    pattern_t entry_pattern_first_reg;
    length_t  entry_first_length_reg;
    pattern_t entry_pattern_second_reg;
    length_t  entry_second_length_reg;

    // Detector state
    logic armed_reg,      armed_next;
    logic entry_mode_reg, entry_mode_next;
    idx_t first_idx_reg,  first_idx_next;
    idx_t second_idx_reg, second_idx_next;

    // Output register
    logic     out_valid_reg;
    verdict_t verdict_reg;

    logic     accept;
    logic     cfg_hit;
    logic     mode;
    idx_t     first_idx;
    idx_t     second_idx;
    pattern_t first_pattern;
    length_t  first_len;
    logic     first_hit;
    logic     first_done;
    logic     second_hit;
    logic     second_done;
    verdict_t item_verdict;

    function automatic length_t eff_len(input length_t len);
        length_t r;
        if (len == '0)
            r = LEN_W'(1);
        else if (len > MAX_LEN)
            r = MAX_LEN;
        else
            r = len;
        return r;
    endfunction

    function automatic logic byte_hit(input pattern_t pat, input idx_t i, input rx_byte_t b);
        rx_byte_t pb;
        pb = pat[{i, 3'b000} +: BYTE_W];
        return (pb == b) || (pb == WILDCARD_BYTE);
    endfunction

    function automatic logic at_end(input idx_t i, input length_t len);
        return (LEN_W'(i) + LEN_W'(1)) >= eff_len(len);
    endfunction

    assign in_ch.ready   = !out_valid_reg || out_ch.ready;
    assign accept        = in_ch.valid && in_ch.ready;
    assign out_ch.valid  = out_valid_reg;
    assign out_ch.verdict = verdict_reg;
    assign cfg_hit       = cfg_we && (cfg_index <= REG_ENTRY_SECOND_LENGTH);

    // When idle the incoming wait kind chooses the patterns and indices restart
    assign mode       = armed_reg ? entry_mode_reg : (in_ch.wait_kind == WAIT_ENTRY);
    assign first_idx  = armed_reg ? first_idx_reg  : '0;
    assign second_idx = armed_reg ? second_idx_reg : '0;

    assign first_pattern = mode ? entry_pattern_first_reg : guard_pattern_reg;
    assign first_len     = mode ? entry_first_length_reg  : guard_length_reg;

    assign first_hit   = byte_hit(first_pattern, first_idx, in_ch.rx_byte);
    assign first_done  = first_hit && at_end(first_idx, first_len);
    assign second_hit  = byte_hit(entry_pattern_second_reg, second_idx, in_ch.rx_byte);
    assign second_done = second_hit && at_end(second_idx, entry_second_length_reg);

    always_comb
    begin
        armed_next      = armed_reg;
        entry_mode_next = entry_mode_reg;
        first_idx_next  = first_idx_reg;
        second_idx_next = second_idx_reg;
        item_verdict    = VERDICT_FIRST;
        if (!matching_enabled_reg)
        begin
            item_verdict = VERDICT_FIRST;
        end
        else if (!armed_reg && (in_ch.wait_kind != WAIT_GUARD)
                 && (in_ch.wait_kind != WAIT_ENTRY))
        begin
            item_verdict = VERDICT_FIRST;
        end
        else if (first_done)
        begin
            armed_next      = 1'b0;
            entry_mode_next = 1'b0;
            first_idx_next  = '0;
            second_idx_next = '0;
            item_verdict    = VERDICT_FIRST;
        end
        else if (mode && second_done)
        begin
            armed_next      = 1'b0;
            entry_mode_next = 1'b0;
            first_idx_next  = '0;
            second_idx_next = '0;
            item_verdict    = VERDICT_SECOND;
        end
        else
        begin
            armed_next      = 1'b1;
            entry_mode_next = mode;
            first_idx_next  = first_hit ? first_idx + IDX_W'(1) : '0;
            if (mode)
                second_idx_next = second_hit ? second_idx + IDX_W'(1) : '0;
            else
                second_idx_next = second_idx;
            item_verdict    = VERDICT_NONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matching_enabled_reg     <= 1'b0;
            guard_pattern_reg        <= '0;
            guard_length_reg         <= LEN_W'(1);
            entry_pattern_first_reg  <= '0;
            entry_first_length_reg   <= LEN_W'(1);
            entry_pattern_second_reg <= '0;
            entry_second_length_reg  <= LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MATCHING_ENABLED:     matching_enabled_reg     <= cfg_data[0];
                REG_GUARD_PATTERN:        guard_pattern_reg        <= cfg_data;
                REG_GUARD_LENGTH:         guard_length_reg         <= cfg_data[LEN_W-1:0];
                REG_ENTRY_PATTERN_FIRST:  entry_pattern_first_reg  <= cfg_data;
                REG_ENTRY_FIRST_LENGTH:   entry_first_length_reg   <= cfg_data[LEN_W-1:0];
                REG_ENTRY_PATTERN_SECOND: entry_pattern_second_reg <= cfg_data;
                REG_ENTRY_SECOND_LENGTH:  entry_second_length_reg  <= cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg      <= 1'b0;
            entry_mode_reg <= 1'b0;
            first_idx_reg  <= '0;
            second_idx_reg <= '0;
        end
        else if (cfg_hit)
        begin
            // Drop any partial match on a register write
            armed_reg      <= 1'b0;
            entry_mode_reg <= 1'b0;
            first_idx_reg  <= '0;
            second_idx_reg <= '0;
        end
        else if (accept)
        begin
            armed_reg      <= armed_next;
            entry_mode_reg <= entry_mode_next;
            first_idx_reg  <= first_idx_next;
            second_idx_reg <= second_idx_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            verdict_reg <= item_verdict;
    end

    // A completed match always returns the detector to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && matching_enabled_reg && (item_verdict != VERDICT_NONE) |=> !armed_reg)
        else $error("detector still armed after a match");

    // With matching disabled every item passes
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !matching_enabled_reg |=> out_valid_reg && (verdict_reg == VERDICT_FIRST))
        else $error("pass verdict missing with matching disabled");

    // Input stalls only behind a waiting verdict
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ch.ready |-> out_valid_reg && !out_ch.ready)
        else $error("input stalled without a pending verdict");

    // A guard match never reports the second pattern
    assert property (@(posedge clk) disable iff (!rst_n)
        accept && !mode |-> item_verdict != VERDICT_SECOND)
        else $error("second verdict in guard mode");

endmodule

[verif/tb_dual_byte_sequence_detector_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_byte_sequence_detector_core
// Self-checking bench for the dual byte sequence detector. A directed script
// covers pass mode, unknown wait kinds, restart and wildcard matching, length
// clamping and the first-wins tie. Random phases follow, each with a fresh
// register setting, and mostly replay programmed sequences with corruption.
// Every verdict is checked in order against its scripted value or a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_dual_byte_sequence_detector_core
    import dbsd_pkg::*;
();

    localparam int MAX_BYTES       = 8;
    localparam int RANDOM_PHASES   = 14;
    localparam int ITEMS_PER_PHASE = 52;
    localparam int LONG_HOLD       = 160;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 8;

    localparam wait_kind_t WAIT_UNKNOWN = 2'd2;
    localparam wait_kind_t WAIT_SPARE   = 2'd3;
    localparam cfg_index_t REG_UNUSED   = 3'd7;

    localparam int PAT_GUARD   = 0;
    localparam int PAT_ENTRY_A = 1;
    localparam int PAT_ENTRY_B = 2;

    typedef struct {
        bit                    is_reg;
        cfg_index_t            idx;
        logic [CFG_DATA_W-1:0] data;
        wait_kind_t            kind;
        rx_byte_t              rx;
        bit                    known;
        verdict_t              verdict;
    } script_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    cfg_index_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    dbsd_in_if  in_ch();
    dbsd_out_if out_ch();

    dual_byte_sequence_detector_core #(
        .MAX_PATTERN_BYTES (MAX_BYTES)
    ) u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Predictor copy of the registers and the match state
    logic       match_on;
    pattern_t   pats [3];
    length_t    lens [3];
    logic       armed;
    logic       entry_mode;
    logic [2:0] idx_a;
    logic [2:0] idx_b;

    verdict_t    verdicts_due [$];
    script_row_t script [$];
    rx_byte_t    burst_q [$];
    wait_kind_t  burst_lead;
    bit          burst_first;
    bit          tx_burst;
    bit          hold_req;
    int          mismatches;
    int          quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void disarm();
        armed      = 1'b0;
        entry_mode = 1'b0;
        idx_a      = '0;
        idx_b      = '0;
    endfunction

    function automatic int eff_len(length_t l);
        if (l == 0)
            return 1;
        if (l > MAX_BYTES)
            return MAX_BYTES;
        return int'(l);
    endfunction

    // Returns {complete, next index}
    function automatic logic [3:0] pattern_step(pattern_t p, length_t l, logic [2:0] idx,
                                                rx_byte_t rx);
        rx_byte_t pb;
        pb = p[8*idx +: 8];
        if (pb == rx || pb == WILDCARD_BYTE)
        begin
            if (int'(idx) + 1 >= eff_len(l))
                return {1'b1, idx};
            return {1'b0, idx + 3'd1};
        end
        // restart without comparing this byte against byte 0
        return 4'b0000;
    endfunction

    function automatic verdict_t detect_step(wait_kind_t kind, rx_byte_t rx);
        logic [3:0] r;
        if (!match_on)
            return VERDICT_FIRST;
        if (!armed)
        begin
            if (kind == WAIT_GUARD)
                entry_mode = 1'b0;
            else if (kind == WAIT_ENTRY)
                entry_mode = 1'b1;
            else
                return VERDICT_FIRST;
            armed = 1'b1;
            idx_a = '0;
            idx_b = '0;
        end
        if (entry_mode)
        begin
            r = pattern_step(pats[PAT_ENTRY_A], lens[PAT_ENTRY_A], idx_a, rx);
            if (r[3])
            begin
                disarm();
                return VERDICT_FIRST;
            end
            idx_a = r[2:0];
            r = pattern_step(pats[PAT_ENTRY_B], lens[PAT_ENTRY_B], idx_b, rx);
            if (r[3])
            begin
                disarm();
                return VERDICT_SECOND;
            end
            idx_b = r[2:0];
        end
        else
        begin
            r = pattern_step(pats[PAT_GUARD], lens[PAT_GUARD], idx_a, rx);
            if (r[3])
            begin
                disarm();
                return VERDICT_FIRST;
            end
            idx_a = r[2:0];
        end
        return VERDICT_NONE;
    endfunction

    function automatic int draw_wait(bit burst);
        return burst ? 0 : $urandom_range(0, 11);
    endfunction

    function automatic rx_byte_t pick_pattern_byte();
        case ($urandom_range(0, 5))
            0: return WILDCARD_BYTE;
            1: return 8'h2B;
            2: return 8'h1B;
            3: return 8'h41;
            default: return rx_byte_t'($urandom);
        endcase
    endfunction

    function automatic void add_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        script_row_t r;
        r = '{default: 0};
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        script.push_back(r);
    endfunction

    function automatic void add_item(wait_kind_t kind, rx_byte_t rx);
        script_row_t r;
        r = '{default: 0};
        r.kind = kind;
        r.rx   = rx;
        script.push_back(r);
    endfunction

    function automatic void add_known(wait_kind_t kind, rx_byte_t rx, verdict_t v);
        script_row_t r;
        r = '{default: 0};
        r.kind    = kind;
        r.rx      = rx;
        r.known   = 1'b1;
        r.verdict = v;
        script.push_back(r);
    endfunction

    // Hold the input idle until every pending verdict has come back
    task automatic drain();
        in_ch.valid <= 1'b0;
        while (verdicts_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic reg_write(cfg_index_t idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            REG_MATCHING_ENABLED:     match_on = data[0];
            REG_GUARD_PATTERN:        pats[PAT_GUARD] = data;
            REG_GUARD_LENGTH:         lens[PAT_GUARD] = data[LEN_W-1:0];
            REG_ENTRY_PATTERN_FIRST:  pats[PAT_ENTRY_A] = data;
            REG_ENTRY_FIRST_LENGTH:   lens[PAT_ENTRY_A] = data[LEN_W-1:0];
            REG_ENTRY_PATTERN_SECOND: pats[PAT_ENTRY_B] = data;
            REG_ENTRY_SECOND_LENGTH:  lens[PAT_ENTRY_B] = data[LEN_W-1:0];
            default: ;
        endcase
        if (idx <= REG_ENTRY_SECOND_LENGTH)
            disarm();
    endtask

    // Offer one item, wait for it to be taken, then record its verdict
    task automatic send_item(wait_kind_t kind, rx_byte_t rx, bit known, verdict_t v);
        int gap;
        verdict_t pred;
        cfg_we <= 1'b0;
        gap = draw_wait(tx_burst);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.wait_kind <= kind;
        in_ch.rx_byte   <= rx;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        pred = detect_step(kind, rx);
        verdicts_due.push_back(known ? v : pred);
    endtask

    task automatic random_setup(int style);
        logic [CFG_DATA_W-1:0] vals [7];
        length_t ln [3];
        int start;
        int k;
        for (k = 0; k < 7; k++)
            vals[k] = {$urandom, $urandom};
        for (k = 0; k < 3; k++)
        begin
            case (style)
                0: ln[k] = 4'd8;
                1: ln[k] = 4'd1;
                2: ln[k] = (k == 0) ? 4'd0 : (k == 1) ? 4'd15 : 4'd9;
                3: ln[k] = 4'd8;
                default: ln[k] = ($urandom_range(0, 9) < 7) ? length_t'($urandom_range(1, 8))
                                                            : length_t'($urandom_range(0, 15));
            endcase
        end
        for (k = 0; k < MAX_BYTES; k++)
        begin
            vals[REG_GUARD_PATTERN][8*k +: 8]        = pick_pattern_byte();
            vals[REG_ENTRY_PATTERN_FIRST][8*k +: 8]  = pick_pattern_byte();
            vals[REG_ENTRY_PATTERN_SECOND][8*k +: 8] = pick_pattern_byte();
        end
        if (style == 3)
        begin
            vals[REG_GUARD_PATTERN]        = '1;
            vals[REG_ENTRY_PATTERN_FIRST]  = '0;
            vals[REG_ENTRY_PATTERN_SECOND] = {MAX_BYTES{WILDCARD_BYTE}};
        end
        vals[REG_GUARD_LENGTH][LEN_W-1:0]        = ln[PAT_GUARD];
        vals[REG_ENTRY_FIRST_LENGTH][LEN_W-1:0]  = ln[PAT_ENTRY_A];
        vals[REG_ENTRY_SECOND_LENGTH][LEN_W-1:0] = ln[PAT_ENTRY_B];
        vals[REG_MATCHING_ENABLED][0] = (style == 4) ? 1'b0 :
                                        (style < 4) ? 1'b1 : ($urandom_range(0, 99) < 85);
        start = $urandom_range(0, 6);
        for (k = 0; k < 7; k++)
            reg_write(cfg_index_t'((start + k) % 7), vals[(start + k) % 7]);
        if ($urandom_range(0, 3) == 0)
            reg_write(REG_UNUSED, {$urandom, $urandom});
    endtask

    // Mostly replay a programmed sequence with rare corruption; otherwise noise
    task automatic next_item(output wait_kind_t kind, output rx_byte_t rx);
        int target;
        int n;
        int j;
        pattern_t p;
        rx_byte_t b;
        if (burst_q.size() == 0)
        begin
            burst_first = 1'b1;
            if ($urandom_range(0, 9) < 7)
            begin
                target     = $urandom_range(0, 2);
                p          = pats[target];
                n          = eff_len(lens[target]);
                burst_lead = (target == PAT_GUARD) ? WAIT_GUARD : WAIT_ENTRY;
                for (j = 0; j < n; j++)
                begin
                    b = p[8*j +: 8];
                    if (b == WILDCARD_BYTE)
                        b = rx_byte_t'($urandom);
                    if ($urandom_range(0, 11) == 0)
                        b = pick_pattern_byte();
                    burst_q.push_back(b);
                end
            end
            else
            begin
                burst_lead = wait_kind_t'($urandom_range(0, 3));
                n = $urandom_range(1, 3);
                for (j = 0; j < n; j++)
                    burst_q.push_back($urandom_range(0, 1) ? pick_pattern_byte()
                                                           : rx_byte_t'($urandom));
            end
        end
        rx   = burst_q.pop_front();
        kind = burst_first ? burst_lead : wait_kind_t'($urandom_range(0, 3));
        burst_first = 1'b0;
    endtask

    // Verdict sink: random stalls, one long hold on request
    initial
    begin : verdict_sink
        int stall;
        int taken;
        bit rx_burst;
        verdict_t want;
        out_ch.ready <= 1'b0;
        taken    = 0;
        rx_burst = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req)
            begin
                hold_req = 1'b0;
                stall    = LONG_HOLD;
            end
            else
                stall = draw_wait(rx_burst);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (out_ch.valid !== 1'b1);
            if (verdicts_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected verdict %0d with nothing pending", out_ch.verdict);
            end
            else
            begin
                want = verdicts_due.pop_front();
                if (out_ch.verdict !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("verdict mismatch: expected %0d, got %0d",
                                 want, out_ch.verdict);
                end
            end
            taken++;
            if (taken % 32 == 0)
                rx_burst = ($urandom_range(0, 3) == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int phase;
        int n;
        wait_kind_t k;
        rx_byte_t b;
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= '0;
        cfg_data        <= '0;
        in_ch.valid     <= 1'b0;
        in_ch.wait_kind <= '0;
        in_ch.rx_byte   <= '0;
        match_on    = 1'b0;
        tx_burst    = 1'b0;
        hold_req    = 1'b0;
        mismatches  = 0;
        burst_first = 1'b0;
        burst_lead  = WAIT_GUARD;
        for (n = 0; n < 3; n++)
        begin
            pats[n] = '0;
            lens[n] = 4'd1;
        end
        disarm();

        // pass mode out of reset
        add_known(WAIT_GUARD, 8'h00, VERDICT_FIRST);
        add_known(WAIT_SPARE, 8'hFF, VERDICT_FIRST);
        add_reg(REG_MATCHING_ENABLED, 64'h1);
        add_reg(REG_GUARD_PATTERN, 64'h2B2B2B);
        add_reg(REG_GUARD_LENGTH, 64'h3);
        add_reg(REG_ENTRY_PATTERN_FIRST, 64'h4401391B);
        add_reg(REG_ENTRY_FIRST_LENGTH, 64'h4);
        add_reg(REG_ENTRY_PATTERN_SECOND, 64'h5B1B);
        add_reg(REG_ENTRY_SECOND_LENGTH, 64'h2);
        // unknown kinds while idle
        add_known(WAIT_UNKNOWN, 8'h2B, VERDICT_FIRST);
        add_known(WAIT_SPARE, 8'h00, VERDICT_FIRST);
        // guard, with kinds ignored once armed
        add_item(WAIT_GUARD, 8'h2B);
        add_item(WAIT_ENTRY, 8'h2B);
        add_item(WAIT_UNKNOWN, 8'h2B);
        // guard restart on a stray byte
        add_item(WAIT_GUARD, 8'h2B);
        add_item(WAIT_GUARD, 8'h2B);
        add_item(WAIT_GUARD, 8'h00);
        add_item(WAIT_GUARD, 8'h2B);
        add_item(WAIT_GUARD, 8'h2B);
        add_item(WAIT_GUARD, 8'h2B);
        // first entry through its wildcard, then the alternative
        add_item(WAIT_ENTRY, 8'h1B);
        add_item(WAIT_ENTRY, 8'h39);
        add_item(WAIT_ENTRY, 8'hFF);
        add_item(WAIT_ENTRY, 8'h44);
        add_item(WAIT_ENTRY, 8'h1B);
        add_item(WAIT_ENTRY, 8'h5B);
        // both entries complete on one byte; zero length acts as one
        add_reg(REG_ENTRY_PATTERN_FIRST, 64'hFFFF_FFFF_FFFF_FF01);
        add_reg(REG_ENTRY_FIRST_LENGTH, 64'h0);
        add_reg(REG_ENTRY_PATTERN_SECOND, 64'hFF);
        add_reg(REG_ENTRY_SECOND_LENGTH, 64'hFFFF_FFFF_FFFF_FFF1);
        add_known(WAIT_ENTRY, 8'hFF, VERDICT_FIRST);
        add_reg(REG_GUARD_PATTERN, 64'hFF);
        add_reg(REG_GUARD_LENGTH, 64'h0);
        add_known(WAIT_GUARD, 8'hFE, VERDICT_NONE);
        // a write to an unused index keeps the detector armed
        add_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        add_item(WAIT_UNKNOWN, 8'hFF);
        add_reg(REG_MATCHING_ENABLED, 64'hFFFF_FFFF_FFFF_FFFE);
        add_known(WAIT_ENTRY, 8'h55, VERDICT_FIRST);

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (script[i])
        begin
            if (script[i].is_reg)
            begin
                drain();
                reg_write(script[i].idx, script[i].data);
            end
            else
                send_item(script[i].kind, script[i].rx, script[i].known, script[i].verdict);
        end

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            random_setup(phase);
            burst_q.delete();
            tx_burst = ($urandom_range(0, 3) == 0) || phase == 2 || phase == 8;
            // stall the sink long enough to back up the input
            if (phase == 2 || phase == 8)
                hold_req = 1'b1;
            for (n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (phase == 6 && n == ITEMS_PER_PHASE / 2)
                    drain();
                next_item(k, b);
                send_item(k, b, 1'b0, VERDICT_NONE);
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && verdicts_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

[files.f]
hw/rtl/dbsd_pkg.sv
hw/rtl/dbsd_if.sv
hw/rtl/dual_byte_sequence_detector_core.sv
verif/tb_dual_byte_sequence_detector_core.sv
